// File: hw/rtl/queued_beep_tone_sequencer_top_macros.svh
// assertion macros shared by the tone sequencer checker
// no dependencies; included by the checker file
`ifndef QUEUED_BEEP_TONE_SEQUENCER_TOP_MACROS_SVH
`define QUEUED_BEEP_TONE_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication under reset
`define QBTS_ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("tone sequencer assertion failed");

// next-cycle implication under reset
`define QBTS_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("tone sequencer assertion failed");

`endif

// File: hw/rtl/qbts_pkg.sv
// shared constants, command/status structs and helpers of the tone sequencer
// no dependencies
package qbts_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int FREQ_W      = 16;
	localparam int DUR_W       = 16;
	localparam int PERIOD_W    = 30;
	localparam int HIGH_W      = 29;
	localparam int QCOUNT_W    = 5;
	localparam int ENTRY_W     = FREQ_W + DUR_W;

	localparam logic [PERIOD_W-1:0] NS_PER_S = PERIOD_W'(1000000000);

	// item opcodes
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_BEEP = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic cancel;
		logic push;
		logic dec;
		logic stop;
		logic pop;
		logic apply_zero;
		logic div_start;
		logic apply_div;
		logic drop;
		logic load_out;
	} qbts_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_beep;
		logic is_cancel;
		logic full;
		logic cd_active;
		logic rem_gt1;
		logic empty;
		logic pop_same;
		logic pop_zero;
		logic div_done;
	} qbts_sts_t;

	// circular pointer advance
	function automatic logic [PTR_W-1:0] qbts_ptr_next(input logic [PTR_W-1:0] ptr);
		logic [PTR_W-1:0] nxt;
		if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
			nxt = '0;
		end else begin
			nxt = ptr + 1'b1;
		end
		return nxt;
	endfunction

endpackage

// File: hw/rtl/queued_beep_tone_sequencer_top.sv
// top level of the queued beep tone sequencer
// depends on qbts_pkg, qbts_ctrl, qbts_datapath
//
// channel   direction  handshake                  payload
// beep      in         beep_valid / beep_ready    opcode, beep_frequency, duration_ms
// result    out        result_valid / result_ready tone_on .. settings_changed
// cfg       in         cfg_wr_en                  cfg_wr_data (output polarity)
//
// one item at a time: beeps and plain ticks pass the decide and result states; a pop
// that keeps or silences the tone also passes load and pop, and one that needs a new
// period waits in div for the 30-step radix-2 divider computing 1e9 / f
// the result register frees the input side: a new item is taken while a result waits
// reset is asynchronous active low; fifo contents need no clearing pass
module queued_beep_tone_sequencer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic                          cfg_wr_data,
	input  logic                          beep_valid,
	output logic                          beep_ready,
	input  logic                          opcode,
	input  logic [qbts_pkg::FREQ_W-1:0]   beep_frequency,
	input  logic [qbts_pkg::DUR_W-1:0]    duration_ms,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic                          tone_on,
	output logic [qbts_pkg::PERIOD_W-1:0] period_ns,
	output logic [qbts_pkg::HIGH_W-1:0]   high_time_ns,
	output logic                          inverted,
	output logic [qbts_pkg::FREQ_W-1:0]   frequency_now,
	output logic [qbts_pkg::QCOUNT_W-1:0] queued_count,
	output logic                          dropped,
	output logic                          settings_changed
);
	import qbts_pkg::*;

	qbts_cmd_t cmd;
	qbts_sts_t sts;

	// sequencing
	qbts_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.beep_valid   (beep_valid),
		.beep_ready   (beep_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	// storage and arithmetic
	qbts_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.opcode           (opcode),
		.beep_frequency   (beep_frequency),
		.duration_ms      (duration_ms),
		.tone_on          (tone_on),
		.period_ns        (period_ns),
		.high_time_ns     (high_time_ns),
		.inverted         (inverted),
		.frequency_now    (frequency_now),
		.queued_count     (queued_count),
		.dropped          (dropped),
		.settings_changed (settings_changed)
	);

endmodule

// File: hw/rtl/qbts_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module qbts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/qbts_div.sv
// radix-2 restoring divider: one second in ns divided by a frequency
// depends on qbts_pkg
module qbts_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [qbts_pkg::FREQ_W-1:0]    divisor,
	output logic                           done,
	output logic [qbts_pkg::PERIOD_W-1:0]  quotient
);
	import qbts_pkg::*;

	localparam int STEP_W = $clog2(PERIOD_W);

	logic [FREQ_W-1:0]   rem_q;
	logic [PERIOD_W-1:0] quo_q;
	logic [FREQ_W-1:0]   dvs_q;
	logic [STEP_W-1:0]   cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [FREQ_W:0]     trial;
	logic [FREQ_W:0]     diff;
	logic                ge;

	// one quotient bit per step
	assign trial = {rem_q, quo_q[PERIOD_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(PERIOD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= NS_PER_S;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
			quo_q <= {quo_q[PERIOD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: hw/rtl/qbts_datapath.sv
// datapath: item capture, beep fifo, countdown, pwm settings, result register
// depends on qbts_pkg, qbts_ram, qbts_div
module qbts_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  qbts_pkg::qbts_cmd_t           cmd,
	output qbts_pkg::qbts_sts_t           sts,
	input  logic                          cfg_wr_en,
	input  logic                          cfg_wr_data,
	input  logic                          opcode,
	input  logic [qbts_pkg::FREQ_W-1:0]   beep_frequency,
	input  logic [qbts_pkg::DUR_W-1:0]    duration_ms,
	output logic                          tone_on,
	output logic [qbts_pkg::PERIOD_W-1:0] period_ns,
	output logic [qbts_pkg::HIGH_W-1:0]   high_time_ns,
	output logic                          inverted,
	output logic [qbts_pkg::FREQ_W-1:0]   frequency_now,
	output logic [qbts_pkg::QCOUNT_W-1:0] queued_count,
	output logic                          dropped,
	output logic                          settings_changed
);
	import qbts_pkg::*;

	logic                op_q;
	logic [FREQ_W-1:0]   freq_q;
	logic [DUR_W-1:0]    dur_q;
	logic [PTR_W-1:0]    rp_q;
	logic [PTR_W-1:0]    wp_q;
	logic [CNT_W-1:0]    count_q;
	logic                cd_active_q;
	logic [DUR_W-1:0]    rem_ms_q;
	logic [FREQ_W-1:0]   cur_freq_q;
	logic [PERIOD_W-1:0] cur_period_q;
	logic [FREQ_W-1:0]   pf_q;
	logic                inv_q;
	logic                changed_q;
	logic                dropped_q;
	logic [ENTRY_W-1:0]  rd_entry;
	logic [FREQ_W-1:0]   rd_freq;
	logic [DUR_W-1:0]    rd_dur;
	logic                div_done;
	logic [PERIOD_W-1:0] div_quo;

	// incoming item capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= opcode;
			freq_q <= beep_frequency;
			dur_q  <= duration_ms;
		end
	end

	// polarity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q <= 1'b0;
		end else if (cfg_wr_en) begin
			inv_q <= cfg_wr_data;
		end
	end

	// fifo storage, read address follows the read pointer
	qbts_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo_ram (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (wp_q),
		.wdata ({freq_q, dur_q}),
		.raddr (rp_q),
		.rdata (rd_entry)
	);

	assign rd_freq = rd_entry[ENTRY_W-1:DUR_W];
	assign rd_dur  = rd_entry[DUR_W-1:0];

	// period divider
	qbts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.divisor  (rd_freq),
		.done     (div_done),
		.quotient (div_quo)
	);

	// fifo pointers, fill count and countdown
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q        <= '0;
			wp_q        <= '0;
			count_q     <= '0;
			cd_active_q <= 1'b0;
			rem_ms_q    <= '0;
		end else begin
			priority if (cmd.cancel) begin
				rp_q        <= '0;
				wp_q        <= '0;
				count_q     <= '0;
				cd_active_q <= 1'b0;
				rem_ms_q    <= '0;
			end else if (cmd.push) begin
				wp_q    <= qbts_ptr_next(wp_q);
				count_q <= count_q + 1'b1;
				// first entry restarts a one-tick countdown
				if (count_q == '0) begin
					cd_active_q <= 1'b1;
					rem_ms_q    <= DUR_W'(1);
				end
			end else if (cmd.dec) begin
				rem_ms_q <= rem_ms_q - 1'b1;
			end else if (cmd.stop) begin
				cd_active_q <= 1'b0;
				rem_ms_q    <= '0;
			end else if (cmd.pop) begin
				rp_q     <= qbts_ptr_next(rp_q);
				count_q  <= count_q - 1'b1;
				rem_ms_q <= (rd_dur == '0) ? DUR_W'(1) : rd_dur;
			end else begin
				rp_q <= rp_q;
			end
		end
	end

	// popped frequency, held for the divider result
	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			pf_q <= rd_freq;
		end
	end

	// current pwm setting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_freq_q   <= '0;
			cur_period_q <= '0;
		end else if (cmd.apply_zero) begin
			cur_freq_q   <= '0;
			cur_period_q <= '0;
		end else if (cmd.apply_div) begin
			cur_freq_q   <= pf_q;
			cur_period_q <= div_quo;
		end
	end

	// per-item flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			changed_q <= 1'b0;
			dropped_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				changed_q <= 1'b0;
				dropped_q <= 1'b0;
			end
			if (cmd.apply_zero) begin
				changed_q <= (cur_freq_q != '0);
			end
			if (cmd.apply_div) begin
				changed_q <= 1'b1;
			end
			if (cmd.drop) begin
				dropped_q <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			tone_on          <= (cur_freq_q != '0);
			period_ns        <= cur_period_q;
			high_time_ns     <= cur_period_q[PERIOD_W-1:1];
			inverted         <= inv_q;
			frequency_now    <= cur_freq_q;
			queued_count     <= QCOUNT_W'(count_q);
			dropped          <= dropped_q;
			settings_changed <= changed_q;
		end
	end

	// status to the controller
	always_comb begin
		sts.is_beep   = (op_q == OP_BEEP);
		sts.is_cancel = (freq_q == '0) && (dur_q == '0);
		sts.full      = (count_q >= CNT_W'(QUEUE_DEPTH));
		sts.cd_active = cd_active_q;
		sts.rem_gt1   = (rem_ms_q > DUR_W'(1));
		sts.empty     = (count_q == '0);
		sts.pop_same  = (rd_freq == cur_freq_q);
		sts.pop_zero  = (rd_freq == '0);
		sts.div_done  = div_done;
	end

endmodule

// File: hw/rtl/qbts_ctrl.sv
// controller state machine: sequences one item and the result transfer
// depends on qbts_pkg
module qbts_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                beep_valid,
	output logic                beep_ready,
	output logic                result_valid,
	input  logic                result_ready,
	input  qbts_pkg::qbts_sts_t sts,
	output qbts_pkg::qbts_cmd_t cmd
);
	import qbts_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECIDE = 3'd1;
	localparam logic [2:0] ST_LOAD   = 3'd2;
	localparam logic [2:0] ST_POP    = 3'd3;
	localparam logic [2:0] ST_DIV    = 3'd4;
	localparam logic [2:0] ST_RESULT = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free     = !out_valid_q || result_ready;
	assign beep_ready   = (state_q == ST_IDLE);
	assign result_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (beep_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				state_d = ST_RESULT;
				priority if (sts.is_beep) begin
					priority if (sts.is_cancel) begin
						cmd.cancel     = 1'b1;
						cmd.apply_zero = 1'b1;
					end else if (sts.full) begin
						cmd.drop = 1'b1;
					end else begin
						cmd.push = 1'b1;
					end
				end else if (!sts.cd_active) begin
					state_d = ST_RESULT;
				end else if (sts.rem_gt1) begin
					cmd.dec = 1'b1;
				end else if (sts.empty) begin
					cmd.stop       = 1'b1;
					cmd.apply_zero = 1'b1;
				end else begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				// ram read data for the read pointer lands here
				state_d = ST_POP;
			end
			ST_POP: begin
				cmd.pop = 1'b1;
				priority if (sts.pop_same) begin
					state_d = ST_RESULT;
				end else if (sts.pop_zero) begin
					cmd.apply_zero = 1'b1;
					state_d        = ST_RESULT;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					cmd.apply_div = 1'b1;
					state_d       = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: hw/rtl/qbts_checker.sv
// port-level checks of the tone sequencer, bound to the top level
// depends on qbts_pkg and queued_beep_tone_sequencer_top_macros.svh
`include "queued_beep_tone_sequencer_top_macros.svh"

module qbts_port_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          result_valid,
	input  logic                          result_ready,
	input  logic                          tone_on,
	input  logic [qbts_pkg::PERIOD_W-1:0] period_ns,
	input  logic [qbts_pkg::HIGH_W-1:0]   high_time_ns,
	input  logic [qbts_pkg::FREQ_W-1:0]   frequency_now,
	input  logic                          dropped,
	input  logic                          settings_changed
);
	import qbts_pkg::*;

	// a stalled result holds
	`QBTS_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(period_ns) && $stable(frequency_now))

	// tone on follows the sounding frequency, silence has no period
	`QBTS_ASSERT_IMPLY(a_tone_freq, clk, arst_n, result_valid, tone_on == (frequency_now != '0) && (tone_on || period_ns == '0))

	// half duty
	`QBTS_ASSERT_IMPLY(a_half_duty, clk, arst_n, result_valid, high_time_ns == period_ns[PERIOD_W-1:1])

	// a refused beep changes no setting
	`QBTS_ASSERT_IMPLY(a_drop_no_change, clk, arst_n, result_valid && dropped, !settings_changed)

endmodule

bind queued_beep_tone_sequencer_top qbts_port_checker u_qbts_checker (.*);
